FILE: src/rit_pkg.sv
package rit_pkg;

	// Prescaler: timer cycles per period unit
	localparam int unsigned PRESCALE = 15;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned ADDR_W   = 12;
	localparam int unsigned DATA_W   = 16;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned CTL_W    = 3;

	// A zero period stands for the full 2^16 units
	localparam int unsigned FULL_PERIOD = 1 << PERIOD_W;
	localparam int unsigned CNT_W       = $clog2(FULL_PERIOD * PRESCALE + 1);

	// Counter readout: ceil(count / PRESCALE) by reciprocal multiply
	localparam int unsigned SUM_W    = CNT_W + 1;
	localparam int unsigned RECIP_SH = CNT_W + $clog2(PRESCALE) + 2;
	localparam int unsigned RECIP_W  = RECIP_SH + 1;
	localparam longint unsigned RECIP = ((64'd1 << RECIP_SH) + PRESCALE - 1) / PRESCALE;
	localparam int unsigned PROD_W   = SUM_W + RECIP_W;

	// Register map
	localparam logic [ADDR_W-1:0] SEL_MASK    = 12'hFC0;
	localparam logic [ADDR_W-1:0] REG_CONTROL = 12'hF00;
	localparam logic [ADDR_W-1:0] REG_PERIOD  = 12'hF80;
	localparam logic [ADDR_W-1:0] REG_COUNTER = 12'hFC0;

	// Control bit positions
	localparam int unsigned CTL_IRQ_EN = 0;
	localparam int unsigned CTL_RUN    = 1;
	localparam int unsigned CTL_FLAG   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_TICK       = 2'd0,
		OP_READ_HALF  = 2'd1,
		OP_READ_BYTE  = 2'd2,
		OP_WRITE_HALF = 2'd3
	} op_t;

	typedef struct packed {
		op_t               operation;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_data;
	} req_t;

	typedef struct packed {
		logic [CTL_W-1:0]    ctl;
		logic [PERIOD_W-1:0] period;
		logic [CNT_W-1:0]    count;
	} state_t;

	// Reload value in timer cycles
	function automatic logic [CNT_W-1:0] period_cycles(input logic [PERIOD_W-1:0] period);
		logic [PERIOD_W:0] units;
		logic [CNT_W-1:0]  cycles;
		units  = (period == '0) ? (PERIOD_W+1)'(FULL_PERIOD) : {1'b0, period};
		cycles = CNT_W'(units) * CNT_W'(PRESCALE);
		return cycles;
	endfunction

endpackage

FILE: src/rit_if.sv
interface rit_req_if;
	logic                                valid;
	logic                                ready;
	rit_pkg::op_t                        operation;
	logic [rit_pkg::ADDR_W-1:0]          address;
	logic [rit_pkg::DATA_W-1:0]          write_data;

	modport source (output valid, output operation, output address, output write_data,
		input ready);
	modport sink (input valid, input operation, input address, input write_data,
		output ready);
endinterface

interface rit_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [rit_pkg::DATA_W-1:0] read_data;
	logic                       irq;

	modport source (output valid, output read_data, output irq, input ready);
	modport sink (input valid, input read_data, input irq, output ready);
endinterface

FILE: src/rit_regs.sv
module rit_regs (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  rit_pkg::req_t   item,
	output rit_pkg::state_t st,
	output logic            flag_next
);

	rit_pkg::state_t              st_q;
	rit_pkg::state_t              nxt;
	logic [rit_pkg::CNT_W-1:0]    eff;

	always_comb begin
		nxt = st_q;
		eff = rit_pkg::period_cycles(st_q.period);
		unique case (item.operation)
			rit_pkg::OP_TICK: begin
				if (st_q.ctl[rit_pkg::CTL_RUN]) begin
					// expire at one (or an unexpected zero): reload, raise flag if interrupts are enabled
					if (st_q.count <= rit_pkg::CNT_W'(1)) begin
						nxt.count = st_q.count + eff - rit_pkg::CNT_W'(1);
						if (st_q.ctl[rit_pkg::CTL_IRQ_EN])
							nxt.ctl[rit_pkg::CTL_FLAG] = 1'b1;
					end else begin
						nxt.count = st_q.count - rit_pkg::CNT_W'(1);
					end
				end
			end
			rit_pkg::OP_WRITE_HALF: begin
				if ((item.address & rit_pkg::SEL_MASK) == rit_pkg::REG_CONTROL) begin
					// load the counter on a rising count enable
					if (!st_q.ctl[rit_pkg::CTL_RUN] && item.write_data[rit_pkg::CTL_RUN])
						nxt.count = eff;
					nxt.ctl = item.write_data[rit_pkg::CTL_W-1:0];
				end else if ((item.address & rit_pkg::SEL_MASK) == rit_pkg::REG_PERIOD) begin
					nxt.period = item.write_data[rit_pkg::PERIOD_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= nxt;
		end
	end

	assign st        = st_q;
	assign flag_next = nxt.ctl[rit_pkg::CTL_FLAG];

endmodule

FILE: src/rit_read.sv
module rit_read (
	input  rit_pkg::state_t             st,
	input  rit_pkg::req_t               item,
	output logic [rit_pkg::DATA_W-1:0]  read_data
);

	logic [rit_pkg::SUM_W-1:0]  sum;
	logic [rit_pkg::PROD_W-1:0] prod;
	logic [rit_pkg::DATA_W-1:0] units;
	logic [rit_pkg::DATA_W-1:0] word;
	logic [rit_pkg::ADDR_W-1:0] sel;

	// ceil(count / PRESCALE) = floor((count + PRESCALE - 1) * RECIP >> RECIP_SH)
	assign sum   = rit_pkg::SUM_W'(st.count) + rit_pkg::SUM_W'(rit_pkg::PRESCALE - 1);
	assign prod  = rit_pkg::PROD_W'(sum) * rit_pkg::PROD_W'(rit_pkg::RECIP);
	assign units = prod[rit_pkg::RECIP_SH +: rit_pkg::DATA_W];
	assign sel   = item.address & rit_pkg::SEL_MASK;

	always_comb begin
		if (sel == rit_pkg::REG_CONTROL)
			word = rit_pkg::DATA_W'(st.ctl);
		else if (sel == rit_pkg::REG_PERIOD)
			word = st.period;
		else if (sel == rit_pkg::REG_COUNTER)
			word = units;
		else
			word = '0;
	end

	always_comb begin
		unique case (item.operation)
			rit_pkg::OP_READ_HALF: read_data = word;
			rit_pkg::OP_READ_BYTE: read_data = item.address[0] ? {8'h00, word[15:8]}
				: {8'h00, word[7:0]};
			default:               read_data = '0;
		endcase
	end

endmodule

FILE: src/reload_interval_timer.sv
// Register-mapped interval timer with a fixed prescaler. Every request is a tick, a
// halfword read, a byte read or a halfword write, and every request yields exactly one
// response carrying read_data (zero for ticks and writes) and irq, the request flag
// after the request took effect. Requests are taken into an input register and
// executed against the timer state; the response lands in an output register, so one
// request per clock is sustained while rsp.ready is held high, and a stalled response
// only holds the pipe while both the input and output registers are full. Registers
// (address bits 11..6): control at 0xF00 (bit0 interrupt enable, bit1 count enable,
// bit2 request flag, writable directly), period at 0xF80 (0 means 65536), counter at
// 0xFC0 (read only, in period units rounded up). Setting count enable loads the
// counter with period times the prescale of 15.
module reload_interval_timer (
	input  logic      clk,
	input  logic      arst_n,
	rit_req_if.sink   req,
	rit_rsp_if.source rsp
);

	// input register
	logic                        valid_s1;
	rit_pkg::req_t               item_s1;

	// output register
	logic                        valid_s2;
	logic [rit_pkg::DATA_W-1:0]  read_data_s2;
	logic                        irq_s2;

	logic                        advance;
	rit_pkg::state_t             st;
	logic                        flag_next;
	logic [rit_pkg::DATA_W-1:0]  read_data;

	// execute the held request when the output register is free or being drained
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.operation  <= req.operation;
			item_s1.address    <= req.address;
			item_s1.write_data <= req.write_data;
		end
	end

	// timer state and its update
	rit_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (item_s1),
		.st        (st),
		.flag_next (flag_next)
	);

	// reads see the state before this request; reads change nothing
	rit_read u_read (
		.st        (st),
		.item      (item_s1),
		.read_data (read_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_s2 <= read_data;
			irq_s2       <= flag_next;
		end
	end

	assign rsp.valid     = valid_s2;
	assign rsp.read_data = read_data_s2;
	assign rsp.irq       = irq_s2;

endmodule
